// ----- hw/rtl/ibms_pkg.sv -----
package ibms_pkg;

    localparam int SCORE_W        = 32;
    localparam int IN_VALUE_W     = 8;
    localparam int MAX_VALUE_BITS = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_OUTER,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } ibms_state_t;

    // sequencer to score unit, issued in the cycle before the memory read data
    typedef struct packed {
        logic issue;     // split step issued
        logic l_empty;   // left sub-interval empty
        logic r_empty;   // right sub-interval empty
        logic outer_rd;  // neighbor operands read
        logic l_pad;     // left neighbor is the pad end
        logic r_pad;     // right neighbor is the pad end
        logic clear;     // start of a new interval
    } ibms_ctl_t;

endpackage

// ----- hw/rtl/ibms_ram.sv -----
module ibms_ram
#(
    parameter int AW = 6,
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/ibms_score_unit.sv -----
module ibms_score_unit
    import ibms_pkg::*;
#(
    parameter int VALUE_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ibms_ctl_t             ctl,
    input  logic [VALUE_BITS-1:0] store_a,
    input  logic [VALUE_BITS-1:0] store_b,
    input  logic [SCORE_W-1:0]    tbl_l,
    input  logic [SCORE_W-1:0]    tbl_r,
    output logic                  busy,
    output logic [SCORE_W-1:0]    best
);

    localparam int OUT_W  = 2 * VALUE_BITS;
    localparam int PROD_W = 3 * VALUE_BITS;
    localparam int SUM_W  = SCORE_W + 1;
    localparam int TOT_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    logic                  s1_vld_reg, s1_le_reg, s1_re_reg;
    logic                  om_vld_reg, om_lp_reg, om_rp_reg;
    logic                  s2_vld_reg, s3_vld_reg;
    logic [OUT_W-1:0]      outer_reg, outer_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SCORE_W-1:0]    tot_reg, tot_next;
    logic [SCORE_W-1:0]    best_reg, best_next;
    logic [VALUE_BITS-1:0] opa, opb;
    logic [TOT_W-1:0]      tot_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s1_le_reg  <= 1'b0;
            s1_re_reg  <= 1'b0;
            om_vld_reg <= 1'b0;
            om_lp_reg  <= 1'b0;
            om_rp_reg  <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctl.issue;
            s1_le_reg  <= ctl.l_empty;
            s1_re_reg  <= ctl.r_empty;
            om_vld_reg <= ctl.outer_rd;
            om_lp_reg  <= ctl.l_pad;
            om_rp_reg  <= ctl.r_pad;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_comb
    begin
        opa        = om_lp_reg ? VALUE_BITS'(1) : store_a;
        opb        = om_rp_reg ? VALUE_BITS'(1) : store_b;
        outer_next = om_vld_reg ? OUT_W'(opa) * OUT_W'(opb) : outer_reg;
        prod_next  = PROD_W'(outer_reg) * PROD_W'(store_a);
        sum_next   = (s1_le_reg ? SUM_W'(0) : SUM_W'(tbl_l))
                   + (s1_re_reg ? SUM_W'(0) : SUM_W'(tbl_r));
        tot_full   = TOT_W'(prod_reg) + TOT_W'(sum_reg);
        tot_next   = (|tot_full[TOT_W-1:SCORE_W]) ? '1 : tot_full[SCORE_W-1:0];
        best_next  = best_reg;
        if (ctl.clear)
        begin
            best_next = '0;
        end
        else if (s3_vld_reg && (tot_reg > best_reg))
        begin
            best_next = tot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        outer_reg <= outer_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        tot_reg   <= tot_next;
        best_reg  <= best_next;
    end

    assign busy = s1_vld_reg | s2_vld_reg | s3_vld_reg;
    assign best = best_reg;

endmodule

// ----- hw/rtl/ibms_ctrl.sv -----
module ibms_ctrl
    import ibms_pkg::*;
#(
    parameter int MAX_BALLOONS = 64,
    parameter int IDX_W        = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SCORE_W-1:0]   m_score,
    output logic                 m_ovf,
    output logic                 st_we,
    output logic [IDX_W-1:0]     st_waddr,
    output logic [IDX_W-1:0]     st_raddr_a,
    output logic [IDX_W-1:0]     st_raddr_b,
    output logic                 tb_we,
    output logic [2*IDX_W-1:0]   tb_waddr,
    output logic [2*IDX_W-1:0]   tb_raddr_l,
    output logic [2*IDX_W-1:0]   tb_raddr_r,
    output ibms_ctl_t            ctl,
    input  logic                 dp_busy,
    input  logic [SCORE_W-1:0]   dp_best
);

    localparam int CNT_W = $clog2(MAX_BALLOONS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BALLOONS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    ibms_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               ovf_res_reg, ovf_res_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic               m_ovf_reg, m_ovf_next;
    logic               room, out_free, row_end, last_cell;
    logic [CNT_W-1:0]   i_m1, i_m2, j_m1, k_m1, k_m2;

    assign room      = (count_reg != MAX_CNT);
    assign out_free  = !m_valid_reg || m_ready;
    assign row_end   = (j_reg == n_reg);
    assign last_cell = row_end && (i_reg == ONE);
    assign i_m1      = i_reg - ONE;
    assign i_m2      = i_reg - TWO;
    assign j_m1      = j_reg - ONE;
    assign k_m1      = k_reg - ONE;
    assign k_m2      = k_reg - TWO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            ovf_res_reg <= 1'b0;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            ovf_res_reg <= ovf_res_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        m_ovf_reg <= m_ovf_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_valid && s_last)
                begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (k_reg == j_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_busy)
                begin
                    state_next = last_cell ? ST_DONE : ST_OUTER;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // counters and result register
    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        ovf_res_next = ovf_res_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        score_next   = score_reg;
        m_ovf_next   = m_ovf_reg;
        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (s_valid)
                begin
                    if (room)
                    begin
                        count_next = count_reg + ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_last)
                    begin
                        n_next       = room ? count_reg + ONE : count_reg;
                        ovf_res_next = ovf_reg || !room;
                        i_next       = n_next;
                        j_next       = n_next;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                    end
                end
            end
            ST_OUTER:
            begin
                k_next = i_reg;
            end
            ST_RUN:
            begin
                if (k_reg != j_reg)
                begin
                    k_next = k_reg + ONE;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_busy && !last_cell)
                begin
                    if (row_end)
                    begin
                        i_next = i_m1;
                        j_next = i_m1;
                    end
                    else
                    begin
                        j_next = j_reg + ONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    score_next   = dp_best;
                    m_ovf_next   = ovf_res_reg;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_ready     = 1'b0;
        st_we       = 1'b0;
        st_waddr    = count_reg[IDX_W-1:0];
        st_raddr_a  = k_m1[IDX_W-1:0];
        st_raddr_b  = j_reg[IDX_W-1:0];
        tb_we       = 1'b0;
        tb_waddr    = {i_m1[IDX_W-1:0], j_m1[IDX_W-1:0]};
        tb_raddr_l  = {i_m1[IDX_W-1:0], k_m2[IDX_W-1:0]};
        tb_raddr_r  = {k_reg[IDX_W-1:0], j_m1[IDX_W-1:0]};
        ctl         = '0;
        case (state_reg)
            ST_LOAD:
            begin
                s_ready = 1'b1;
                st_we   = s_valid && room;
            end
            ST_OUTER:
            begin
                st_raddr_a   = i_m2[IDX_W-1:0];
                ctl.outer_rd = 1'b1;
                ctl.l_pad    = (i_reg == ONE);
                ctl.r_pad    = row_end;
                ctl.clear    = 1'b1;
            end
            ST_RUN:
            begin
                ctl.issue   = 1'b1;
                ctl.l_empty = (k_reg == i_reg);
                ctl.r_empty = (k_reg == j_reg);
            end
            ST_DRAIN:
            begin
                tb_we = !dp_busy;
            end
            ST_DONE:
            begin
                s_ready = 1'b0;
            end
            default:
            begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_score = score_reg;
    assign m_ovf   = m_ovf_reg;

endmodule

// ----- hw/rtl/interval_burst_max_score.sv -----
// interval_burst_max_score: burst-balloons interval score.
// Input stream s_axis: one balloon value per request in tdata, tlast marks the
// final balloon of a sequence and starts the table fill. Up to MAX_BALLOONS
// are kept; later ones are dropped and flagged. Values use their low
// VALUE_BITS bits.
// Output stream m_axis: one request per sequence, tdata = best score
// (saturating at all ones), tuser = overflow flag.
// The input stays ready while loading. After tlast the shared
// multiply/add/compare unit runs one split step per cycle; each interval
// adds a neighbor fetch and a pipeline drain and write. Once the fill is
// done, the result goes to the output register when that register is free.
// s_axis_tready is low from tlast until the result is registered.
// A stalled result holds in the output register; the next sequence may load
// meanwhile, but its result waits until the previous one is taken.
// Reset empties the balloon count, clears the overflow flag and drops any
// pending result; the score table needs no clearing.
module interval_burst_max_score
    import ibms_pkg::*;
#(
    parameter int MAX_BALLOONS = 64,
    parameter int VALUE_BITS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_VALUE_W-1:0] s_axis_tdata,   // [7:0] balloon_value
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SCORE_W-1:0]    m_axis_tdata,   // [31:0] max_score
    output logic                  m_axis_tuser    // [0] overflowed
);

    localparam int IDX_W = (MAX_BALLOONS > 1) ? $clog2(MAX_BALLOONS) : 1;

    logic [MAX_VALUE_BITS-1:0] value_wide;
    logic [VALUE_BITS-1:0]     value;
    logic                      st_we;
    logic [IDX_W-1:0]          st_waddr, st_raddr_a, st_raddr_b;
    logic [VALUE_BITS-1:0]     st_rdata_a, st_rdata_b;
    logic                      tb_we;
    logic [2*IDX_W-1:0]        tb_waddr, tb_raddr_l, tb_raddr_r;
    logic [SCORE_W-1:0]        tb_rdata_l, tb_rdata_r;
    ibms_ctl_t                 ctl;
    logic                      dp_busy;
    logic [SCORE_W-1:0]        dp_best;

    assign value_wide = {{(MAX_VALUE_BITS-IN_VALUE_W){1'b0}}, s_axis_tdata};
    assign value      = value_wide[VALUE_BITS-1:0];

    ibms_ctrl #(
        .MAX_BALLOONS (MAX_BALLOONS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_last     (s_axis_tlast),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_score    (m_axis_tdata),
        .m_ovf      (m_axis_tuser),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_raddr_a (st_raddr_a),
        .st_raddr_b (st_raddr_b),
        .tb_we      (tb_we),
        .tb_waddr   (tb_waddr),
        .tb_raddr_l (tb_raddr_l),
        .tb_raddr_r (tb_raddr_r),
        .ctl        (ctl),
        .dp_busy    (dp_busy),
        .dp_best    (dp_best)
    );

    ibms_ram #(
        .AW (IDX_W),
        .DW (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (value),
        .raddr_a (st_raddr_a),
        .raddr_b (st_raddr_b),
        .rdata_a (st_rdata_a),
        .rdata_b (st_rdata_b)
    );

    ibms_ram #(
        .AW (2*IDX_W),
        .DW (SCORE_W)
    ) u_table (
        .clk     (clk),
        .we      (tb_we),
        .waddr   (tb_waddr),
        .wdata   (dp_best),
        .raddr_a (tb_raddr_l),
        .raddr_b (tb_raddr_r),
        .rdata_a (tb_rdata_l),
        .rdata_b (tb_rdata_r)
    );

    ibms_score_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_score (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .store_a (st_rdata_a),
        .store_b (st_rdata_b),
        .tbl_l   (tb_rdata_l),
        .tbl_r   (tb_rdata_r),
        .busy    (dp_busy),
        .best    (dp_best)
    );

endmodule

// ----- hw/rtl/ibms_checker.sv -----
module ibms_checker
    import ibms_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [SCORE_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    // a final balloon starts the fill: input closes next cycle
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after final balloon");

    // plain balloons keep the input open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input closed while loading");

    // a new result appears only as the block reopens its input
    a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while input closed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind interval_burst_max_score ibms_checker u_ibms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
